// ===== hdl/dense_layer_forward_macros.svh =====
// Assertion macros shared by the dense layer RTL.
`ifndef DENSE_LAYER_FORWARD_MACROS_SVH
`define DENSE_LAYER_FORWARD_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define DLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define DLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dlf_pkg.sv =====
// Types, constants and tables of the dense layer.
`timescale 1ns / 1ps
package dlf_pkg;

  localparam int VAL_W        = 16;
  localparam int FRAC_BITS    = 12;
  localparam int RESULT_LIMIT = 64;
  localparam int EXP_W        = 17;
  localparam int SUM_W        = 23;
  localparam int NUM_W        = 30;
  localparam int DEN_W        = 24;
  localparam int LEAK_W       = 28;
  localparam logic signed [11:0] LEAK_Q16 = 12'sd655;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_INPUT  = 2'd2,
    OP_RUN         = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_SIGMOID = 2'd0,
    ACT_RELU    = 2'd1,
    ACT_LEAKY   = 2'd2,
    ACT_SOFTMAX = 2'd3
  } act_mode_t;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_ACT_MODE     = 2'd2;

  typedef struct packed {
    opcode_t                   opcode;
    logic [5:0]                row_index;
    logic [5:0]                column_index;
    logic signed [VAL_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]                neuron_index;
    logic signed [VAL_W-1:0]   activation_value;
    logic                      last_output;
  } out_item_t;

  // exp(-n) in Q16
  function automatic logic [EXP_W-1:0] exp_int_f(input logic [3:0] n);
    logic [EXP_W-1:0] v;
    unique case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-f/16) in Q16
  function automatic logic [EXP_W-1:0] exp_frac_f(input logic [3:0] f);
    logic [EXP_W-1:0] v;
    unique case (f)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/dlf_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module dlf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dlf_exp.sv =====
// Pipelined exp(-t) unit: Q4.12 argument, Q16 result.
`timescale 1ns / 1ps
module dlf_exp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_v,
  input  logic [15:0]               t,
  output logic                      out_v,
  output logic [dlf_pkg::EXP_W-1:0] e,
  output logic                      busy
);

  logic        va_r, vb_r;
  logic [33:0] m1_r, m2_r;
  logic [16:0] p_r;
  logic [15:0] rr;
  logic [16:0] p_w;
  logic [33:0] v_w;

  // polynomial for the low byte
  always_comb begin
    rr  = 16'(t[7:0]) * 16'(t[7:0]);
    p_w = 17'd65536 - {5'd0, t[7:0], 4'd0} + 17'((17'(rr) + 17'd256) >> 9);
    v_w = (m1_r + 34'd32768) >> 16;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_v;
      vb_r <= va_r;
    end
  end

  // table product, then polynomial product
  always_ff @(posedge clk) begin
    m1_r <= 34'(dlf_pkg::exp_int_f(t[15:12])) * 34'(dlf_pkg::exp_frac_f(t[11:8]));
    p_r  <= p_w;
    m2_r <= 34'(v_w[16:0]) * 34'(p_r);
  end

  assign out_v = vb_r;
  assign e     = dlf_pkg::EXP_W'((m2_r + 34'd32768) >> 16);
  assign busy  = va_r | vb_r;

endmodule

// ===== hdl/dlf_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module dlf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dlf_pkg::NUM_W-1:0] num,
  input  logic [dlf_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [dlf_pkg::NUM_W-1:0] quo
);

  localparam int NW = dlf_pkg::NUM_W;
  localparam int DW = dlf_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r, den_r;
  logic [DW:0]   rs;
  logic          ge;

  // shift in the next numerator bit and trial-subtract
  always_comb begin
    rs = {rem_r, quo_r[NW-1]};
    ge = (rs >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? DW'(rs - {1'b0, den_r}) : DW'(rs);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/dense_layer_forward.sv =====
// Top level of the fully connected layer with activation.
//
// Usage: drive in_data and raise start; an item is taken at an edge where
// start is high and busy is low. Load items (weight, bias, input element)
// never raise busy, so they stream one per cycle while the layer is idle.
// A run item raises busy while the layer walks its memories: each neuron
// reads one weight/input pair per cycle from the weight and input
// memories, then drains the pipeline and stores its result. Softmax adds
// an exp sum pass. For sigmoid and softmax each output then also waits on
// the exp unit and the bit-serial divider (30 steps); relu and leaky relu
// skip both. Results appear on out_data with out_valid high for one cycle
// each, in neuron order, the last one marked; the receiver cannot stall,
// so results are simply presented. Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once and belong in idle time.
// Reset returns counts to 1 and the mode to sigmoid; memory contents are
// not cleared and must be loaded before a run.
`timescale 1ns / 1ps
`include "dense_layer_forward_macros.svh"
module dense_layer_forward #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dlf_pkg::in_item_t  in_data,
  output logic               busy,
  output logic               out_valid,
  output dlf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int VW      = dlf_pkg::VAL_W;
  localparam int OMAX    = (MAX_OUTPUTS < dlf_pkg::RESULT_LIMIT) ? MAX_OUTPUTS
                                                                 : dlf_pkg::RESULT_LIMIT;
  localparam int W_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int IA_W    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int BA_W    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int PA_W    = (OMAX > 1) ? $clog2(OMAX) : 1;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int NI_W    = ($clog2(MAX_INPUTS + 1) > 7) ? $clog2(MAX_INPUTS + 1) : 7;
  localparam int OJ_W    = (OMAX > 1) ? $clog2(OMAX + 1) : 1;
  localparam int ACC_W   = 2 * VW + $clog2(MAX_INPUTS) + 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MAC   = 10'b0000000010,
    S_DRAIN = 10'b0000000100,
    S_FIN   = 10'b0000001000,
    S_SUMRD = 10'b0000010000,
    S_SUMDR = 10'b0000100000,
    S_ORD   = 10'b0001000000,
    S_OWAIT = 10'b0010000000,
    S_EXP   = 10'b0100000000,
    S_DIV   = 10'b1000000000
  } state_t;

  state_t                        state_r;
  logic [6:0]                    in_cnt_r, out_cnt_r;
  dlf_pkg::act_mode_t            mode_r;

  logic [NI_W-1:0]               i_r, ni;
  logic [OJ_W-1:0]               j_r, no;
  logic [WA_W-1:0]               wa_r;
  logic                          dat_v_r, dat_first_r, prd_v_r, sdat_v_r, out_valid_r;
  logic signed [2*VW-1:0]        prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [VW-1:0]          max_r, x_r;
  logic signed [dlf_pkg::LEAK_W-1:0] leak_r;
  logic [dlf_pkg::SUM_W-1:0]     sum_r;
  dlf_pkg::out_item_t            out_data_r;

  logic                          accept, is_run, last_j, emit, exp_act;
  logic                          w_we, b_we, i_we;
  logic [VW-1:0]                 wmem_q, bmem_q, imem_q, pmem_q;
  logic signed [ACC_W-1:0]       rnd_w;
  logic signed [VW-1:0]          pre_w, res_w;
  logic signed [16:0]            diff_w, neg_w;
  logic [15:0]                   exp_t;
  logic                          exp_in_v, exp_out_v, exp_busy;
  logic [dlf_pkg::EXP_W-1:0]     exp_e;
  logic [17:0]                   d_w;
  logic [dlf_pkg::NUM_W-1:0]     num_w, quo_w;
  logic [dlf_pkg::DEN_W-1:0]     den_w;
  logic                          div_start, div_done;
  logic [6:0]                    no7;
  logic signed [dlf_pkg::LEAK_W-1:0] leak_sh;

  // effective counts
  always_comb begin
    if (in_cnt_r == 7'd0) begin
      ni = NI_W'(1);
    end else if (32'(in_cnt_r) > MAX_INPUTS) begin
      ni = NI_W'(MAX_INPUTS);
    end else begin
      ni = NI_W'(in_cnt_r);
    end
    if (out_cnt_r == 7'd0) begin
      no7 = 7'd1;
    end else if (32'(out_cnt_r) > OMAX) begin
      no7 = 7'(OMAX);
    end else begin
      no7 = out_cnt_r;
    end
    no = OJ_W'(no7);
  end

  assign accept = start && !busy;
  assign is_run = (in_data.opcode == dlf_pkg::OP_RUN);
  assign last_j = (j_r == no - 1'b1);
  assign w_we   = accept && (in_data.opcode == dlf_pkg::OP_LOAD_WEIGHT)
                  && (32'(in_data.row_index) < MAX_INPUTS)
                  && (32'(in_data.column_index) < MAX_OUTPUTS);
  assign b_we   = accept && (in_data.opcode == dlf_pkg::OP_LOAD_BIAS)
                  && (32'(in_data.column_index) < MAX_OUTPUTS);
  assign i_we   = accept && (in_data.opcode == dlf_pkg::OP_LOAD_INPUT)
                  && (32'(in_data.row_index) < MAX_INPUTS);

  // stores
  dlf_ram #(.DEPTH(W_DEPTH), .WIDTH(VW)) u_wmem (
    .clk  (clk),
    .we   (w_we),
    .waddr(WA_W'(32'(in_data.row_index) * MAX_OUTPUTS + 32'(in_data.column_index))),
    .wdata(in_data.value),
    .raddr(wa_r),
    .rdata(wmem_q)
  );

  dlf_ram #(.DEPTH(MAX_OUTPUTS), .WIDTH(VW)) u_bmem (
    .clk  (clk),
    .we   (b_we),
    .waddr(BA_W'(in_data.column_index)),
    .wdata(in_data.value),
    .raddr(BA_W'(j_r)),
    .rdata(bmem_q)
  );

  dlf_ram #(.DEPTH(MAX_INPUTS), .WIDTH(VW)) u_imem (
    .clk  (clk),
    .we   (i_we),
    .waddr(IA_W'(in_data.row_index)),
    .wdata(in_data.value),
    .raddr(i_r[IA_W-1:0]),
    .rdata(imem_q)
  );

  dlf_ram #(.DEPTH(OMAX), .WIDTH(VW)) u_pmem (
    .clk  (clk),
    .we   (state_r == S_FIN),
    .waddr(j_r[PA_W-1:0]),
    .wdata(pre_w),
    .raddr(j_r[PA_W-1:0]),
    .rdata(pmem_q)
  );

  // round to Q4.12 and saturate
  always_comb begin
    rnd_w = (acc_r + ACC_W'(2048)) >>> dlf_pkg::FRAC_BITS;
    if (!((&rnd_w[ACC_W-1:VW-1]) || !(|rnd_w[ACC_W-1:VW-1]))) begin
      pre_w = rnd_w[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      pre_w = rnd_w[VW-1:0];
    end
  end

  // exp argument: |x| for sigmoid, max - x for softmax
  assign exp_act = (mode_r == dlf_pkg::ACT_SIGMOID) || (mode_r == dlf_pkg::ACT_SOFTMAX);
  assign diff_w  = {max_r[VW-1], max_r} - {pmem_q[VW-1], pmem_q};
  assign neg_w   = 17'sd0 - {pmem_q[VW-1], pmem_q};
  assign exp_t   = (mode_r == dlf_pkg::ACT_SIGMOID)
                   ? (pmem_q[VW-1] ? neg_w[15:0] : pmem_q) : diff_w[15:0];
  assign exp_in_v = sdat_v_r || ((state_r == S_OWAIT) && exp_act);

  dlf_exp u_exp (
    .clk  (clk),
    .rst_n(rst_n),
    .in_v (exp_in_v),
    .t    (exp_t),
    .out_v(exp_out_v),
    .e    (exp_e),
    .busy (exp_busy)
  );

  // divider operands
  always_comb begin
    d_w = 18'd65536 + 18'(exp_e);
    if (mode_r == dlf_pkg::ACT_SOFTMAX) begin
      num_w = (dlf_pkg::NUM_W'(exp_e) << 13) + dlf_pkg::NUM_W'(sum_r);
      den_w = dlf_pkg::DEN_W'({sum_r, 1'b0});
    end else if (x_r >= 0) begin
      num_w = dlf_pkg::NUM_W'(30'd1 << 29) + dlf_pkg::NUM_W'(d_w);
      den_w = dlf_pkg::DEN_W'({d_w, 1'b0});
    end else begin
      num_w = (dlf_pkg::NUM_W'(exp_e) << 13) + dlf_pkg::NUM_W'(d_w);
      den_w = dlf_pkg::DEN_W'({d_w, 1'b0});
    end
  end

  assign div_start = (state_r == S_EXP) && exp_act && exp_out_v;

  dlf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num_w),
    .den  (den_w),
    .done (div_done),
    .quo  (quo_w)
  );

  // activation result
  always_comb begin
    leak_sh = (leak_r + dlf_pkg::LEAK_W'(32768)) >>> 16;
    unique case (mode_r)
      dlf_pkg::ACT_RELU:  res_w = (x_r > 0) ? x_r : '0;
      dlf_pkg::ACT_LEAKY: res_w = (x_r > 0) ? x_r : leak_sh[VW-1:0];
      default:            res_w = quo_w[VW-1:0];
    endcase
  end

  assign emit = ((state_r == S_EXP) && !exp_act) || ((state_r == S_DIV) && div_done);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= 7'd1;
      out_cnt_r <= 7'd1;
      mode_r    <= dlf_pkg::ACT_SIGMOID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dlf_pkg::CFG_INPUT_COUNT:  in_cnt_r  <= cfg_data;
        dlf_pkg::CFG_OUTPUT_COUNT: out_cnt_r <= cfg_data;
        dlf_pkg::CFG_ACT_MODE:     mode_r    <= dlf_pkg::act_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dat_v_r     <= 1'b0;
      dat_first_r <= 1'b0;
      prd_v_r     <= 1'b0;
      sdat_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dat_v_r     <= (state_r == S_MAC);
      dat_first_r <= (state_r == S_MAC) && (i_r == '0);
      prd_v_r     <= dat_v_r;
      sdat_v_r    <= (state_r == S_SUMRD);
      out_valid_r <= emit;
      unique case (state_r)
        S_IDLE:  if (accept && is_run) state_r <= S_MAC;
        S_MAC:   if (i_r == ni - 1'b1) state_r <= S_DRAIN;
        S_DRAIN: if (!dat_v_r && !prd_v_r) state_r <= S_FIN;
        S_FIN: begin
          if (!last_j) begin
            state_r <= S_MAC;
          end else if (mode_r == dlf_pkg::ACT_SOFTMAX) begin
            state_r <= S_SUMRD;
          end else begin
            state_r <= S_ORD;
          end
        end
        S_SUMRD: if (last_j) state_r <= S_SUMDR;
        S_SUMDR: if (!sdat_v_r && !exp_busy) state_r <= S_ORD;
        S_ORD:   state_r <= S_OWAIT;
        S_OWAIT: state_r <= S_EXP;
        S_EXP: begin
          if (emit) begin
            state_r <= last_j ? S_IDLE : S_ORD;
          end else if (div_start) begin
            state_r <= S_DIV;
          end
        end
        S_DIV:   if (emit) state_r <= last_j ? S_IDLE : S_ORD;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath: counters, accumulator, max, sum, output item
  always_ff @(posedge clk) begin
    prod_r <= $signed(imem_q) * $signed(wmem_q);
    if (dat_first_r) begin
      acc_r <= ACC_W'($signed(bmem_q)) <<< dlf_pkg::FRAC_BITS;
    end else if (prd_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (exp_out_v && ((state_r == S_SUMRD) || (state_r == S_SUMDR))) begin
      sum_r <= sum_r + dlf_pkg::SUM_W'(exp_e);
    end
    if (emit) begin
      out_data_r.neuron_index     <= 6'(j_r);
      out_data_r.activation_value <= res_w;
      out_data_r.last_output      <= last_j;
    end
    unique case (state_r)
      S_IDLE: begin
        j_r   <= '0;
        i_r   <= '0;
        wa_r  <= '0;
        sum_r <= '0;
      end
      S_MAC: begin
        i_r  <= i_r + 1'b1;
        wa_r <= wa_r + WA_W'(MAX_OUTPUTS);
      end
      S_FIN: begin
        if ((j_r == '0) || (pre_w > max_r)) max_r <= pre_w;
        i_r  <= '0;
        wa_r <= WA_W'(32'(j_r) + 1);
        j_r  <= last_j ? '0 : j_r + 1'b1;
      end
      S_SUMRD: if (!last_j) j_r <= j_r + 1'b1;
      S_SUMDR: j_r <= '0;
      S_OWAIT: begin
        x_r    <= pmem_q;
        leak_r <= dlf_pkg::LEAK_W'($signed(pmem_q) * dlf_pkg::LEAK_Q16);
      end
      S_EXP, S_DIV: if (emit) j_r <= j_r + 1'b1;
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `DLF_ASSERT_NXT(a_load_stays_idle, accept && !is_run, !busy, "load item raised busy")
  `DLF_ASSERT_NXT(a_run_goes_busy, accept && is_run, busy, "run item did not raise busy")
  `DLF_ASSERT_NXT(a_last_then_quiet, out_valid && out_data.last_output, !out_valid,
                  "item after last output")
  `DLF_ASSERT_IMP(a_mid_output_busy, out_valid && !out_data.last_output, busy,
                  "run ended before last output")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the dense layer: loads, runs in every mode, config sweeps.
`timescale 1ns / 1ps
module testbench;

  logic               clk;
  logic               rst_n;
  logic               start;
  dlf_pkg::in_item_t  in_data;
  logic               busy;
  logic               out_valid;
  dlf_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;

  dense_layer_forward u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the layer state
  logic signed [15:0] weight_mem [0:4095];
  logic signed [15:0] bias_mem [0:63];
  logic signed [15:0] input_mem [0:63];
  logic [6:0]         n_inputs_reg;
  logic [6:0]         n_outputs_reg;
  dlf_pkg::act_mode_t mode_reg;

  dlf_pkg::out_item_t neuron_queue[$];
  int        mismatches;
  int        items_sent;
  int        results_seen;
  int        runs_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("** dense_layer_forward: FAILED **");
    $finish;
  end

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // exp(-t) in Q16, t in Q4.12 units
  function automatic longint exp_q16(input longint t);
    longint n, f, r, p, v;
    if (t > 65535) return 0;
    n = t >> 12;
    f = (t >> 8) & 15;
    r = t & 255;
    p = 65536 - 16 * r + ((r * r + 256) >> 9);
    v = (longint'(dlf_pkg::exp_int_f(n[3:0])) * longint'(dlf_pkg::exp_frac_f(f[3:0]))
         + 32768) >> 16;
    return (v * p + 32768) >> 16;
  endfunction

  function automatic longint sigmoid_q12(input longint x);
    longint e, d;
    e = exp_q16(x < 0 ? -x : x);
    d = 65536 + e;
    if (x >= 0) return (longint'(4096) * 65536 * 2 + d) / (2 * d);
    return (4096 * 2 * e + d) / (2 * d);
  endfunction

  // Compute every neuron of one run and queue the expected outputs
  task automatic predict_layer();
    longint pre [0:63];
    longint acc, peak, sum, res;
    int     ni, no;
    dlf_pkg::out_item_t o;
    ni = (n_inputs_reg == 0) ? 1 : (n_inputs_reg > 64 ? 64 : n_inputs_reg);
    no = (n_outputs_reg == 0) ? 1 : (n_outputs_reg > 64 ? 64 : n_outputs_reg);
    for (int j = 0; j < no; j++) begin
      acc = longint'(bias_mem[j]) <<< 12;
      for (int i = 0; i < ni; i++)
        acc += longint'(input_mem[i]) * longint'(weight_mem[i * 64 + j]);
      acc = (acc + 2048) >>> 12;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      pre[j] = acc;
    end
    peak = pre[0];
    for (int j = 1; j < no; j++) if (pre[j] > peak) peak = pre[j];
    sum = 0;
    if (mode_reg == dlf_pkg::ACT_SOFTMAX)
      for (int j = 0; j < no; j++) sum += exp_q16(peak - pre[j]);
    for (int j = 0; j < no; j++) begin
      case (mode_reg)
        dlf_pkg::ACT_SIGMOID: res = sigmoid_q12(pre[j]);
        dlf_pkg::ACT_RELU:    res = pre[j] > 0 ? pre[j] : 0;
        dlf_pkg::ACT_LEAKY:   res = pre[j] > 0 ? pre[j] : ((pre[j] * 655 + 32768) >>> 16);
        default:              res = (exp_q16(peak - pre[j]) * 8192 + sum) / (2 * sum);
      endcase
      o.neuron_index     = j[5:0];
      o.activation_value = res[15:0];
      o.last_output      = (j + 1 == no);
      neuron_queue.push_back(o);
    end
  endtask

  // Update the shadow state for one accepted item
  task automatic apply_item(input dlf_pkg::in_item_t it);
    case (it.opcode)
      dlf_pkg::OP_LOAD_WEIGHT: weight_mem[it.row_index * 64 + it.column_index] = it.value;
      dlf_pkg::OP_LOAD_BIAS:   bias_mem[it.column_index] = it.value;
      dlf_pkg::OP_LOAD_INPUT:  input_mem[it.row_index] = it.value;
      default: begin
        predict_layer();
        runs_sent++;
      end
    endcase
  endtask

  // Send one item after a gap; start stays high when the next item follows at once
  task automatic send_item(input dlf_pkg::in_item_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_item(it);
    items_sent++;
  endtask

  // Idle gap before an item: often none, otherwise drawn at random
  function automatic int pick_gap();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic dlf_pkg::in_item_t make_item(input dlf_pkg::opcode_t op, input int row,
                                                  input int col, input int val);
    dlf_pkg::in_item_t it;
    it.opcode       = op;
    it.row_index    = row[5:0];
    it.column_index = col[5:0];
    it.value        = val[15:0];
    return it;
  endfunction

  // Drop start, wait until every expected output has arrived, then let the layer settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (neuron_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input int val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dlf_pkg::CFG_INPUT_COUNT:  n_inputs_reg  = val[6:0];
      dlf_pkg::CFG_OUTPUT_COUNT: n_outputs_reg = val[6:0];
      dlf_pkg::CFG_ACT_MODE:     mode_reg      = dlf_pkg::act_mode_t'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic setup_layer(input int ni, input int no, input dlf_pkg::act_mode_t m);
    write_cfg(dlf_pkg::CFG_INPUT_COUNT, ni);
    write_cfg(dlf_pkg::CFG_OUTPUT_COUNT, no);
    write_cfg(dlf_pkg::CFG_ACT_MODE, m);
  endtask

  function automatic int rand_value();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 8191) - 4096;
  endfunction

  // Fill every entry a run below can read: all inputs and biases, weight
  // column 0 and row 0 in full, and a small block of the other weights
  task automatic test_fill_stores();
    for (int k = 0; k < 64; k++) begin
      send_item(make_item(dlf_pkg::OP_LOAD_INPUT, k, $urandom, rand_value()), pick_gap());
      send_item(make_item(dlf_pkg::OP_LOAD_BIAS, $urandom, k, rand_value()), pick_gap());
      send_item(make_item(dlf_pkg::OP_LOAD_WEIGHT, k, 0, rand_value()), pick_gap());
      if (k > 0)
        send_item(make_item(dlf_pkg::OP_LOAD_WEIGHT, 0, k, rand_value()), pick_gap());
    end
    for (int r = 1; r < 3; r++)
      for (int c = 1; c < 3; c++)
        send_item(make_item(dlf_pkg::OP_LOAD_WEIGHT, r, c, rand_value()), pick_gap());
  endtask

  // Field extremes, saturation, each activation, count clamping
  task automatic test_directed();
    setup_layer(1, 1, dlf_pkg::ACT_SIGMOID);
    send_item(make_item(dlf_pkg::OP_LOAD_INPUT, 0, 63, 32767), pick_gap());
    send_item(make_item(dlf_pkg::OP_LOAD_WEIGHT, 0, 0, 32767), pick_gap());
    send_item(make_item(dlf_pkg::OP_LOAD_BIAS, 63, 0, 32767), pick_gap());
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
    send_item(make_item(dlf_pkg::OP_LOAD_WEIGHT, 0, 0, -32768), pick_gap());
    send_item(make_item(dlf_pkg::OP_LOAD_BIAS, 0, 0, -32768), pick_gap());
    send_item(make_item(dlf_pkg::OP_RUN, 63, 63, -1), pick_gap());
    for (int m = 0; m < 4; m++) begin
      write_cfg(dlf_pkg::CFG_ACT_MODE, m);
      send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
    end
    // zero counts behave as one, oversized counts as the maximum
    setup_layer(0, 0, dlf_pkg::ACT_LEAKY);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
    write_cfg(2'd3, 127);
    setup_layer(1, 127, dlf_pkg::ACT_SOFTMAX);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
    setup_layer(127, 1, dlf_pkg::ACT_SIGMOID);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
    setup_layer(1, 64, dlf_pkg::ACT_RELU);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), pick_gap());
  endtask

  // Random phases: small layers mostly, loads with random content and runs
  task automatic test_random();
    int ni, no, sel;
    dlf_pkg::opcode_t op;
    for (int ph = 0; ph < 4; ph++) begin
      sel = $urandom_range(0, 3);
      ni  = (sel == 0) ? $urandom_range(0, 127)
                       : ((sel == 1) ? $urandom_range(0, 1) : $urandom_range(1, 3));
      no  = (sel == 0) ? 1 : ((sel == 1) ? $urandom_range(0, 127) : $urandom_range(1, 3));
      setup_layer(ni, no, dlf_pkg::act_mode_t'($urandom_range(0, 3)));
      op = ($urandom_range(0, 3) == 0) ? dlf_pkg::OP_RUN
                                       : dlf_pkg::opcode_t'($urandom_range(0, 2));
      send_item(make_item(op, $urandom_range(0, 2), $urandom_range(0, 2), rand_value()),
                pick_gap());
      send_item(make_item(dlf_pkg::OP_RUN, $urandom, $urandom, $urandom), pick_gap());
    end
  endtask

  // Hold the sender until the layer has drained, then go on back to back
  task automatic test_drain_pause();
    setup_layer(2, 3, dlf_pkg::ACT_LEAKY);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), 0);
    start <= 1'b0;
    while (neuron_queue.size() != 0) @(posedge clk);
    send_item(make_item(dlf_pkg::OP_LOAD_INPUT, 1, 0, -20000), 0);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), 0);
    send_item(make_item(dlf_pkg::OP_RUN, 0, 0, 0), 0);
  endtask

  // Check each output against the oldest expected neuron
  always @(posedge clk) begin
    dlf_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (neuron_queue.size() == 0) begin
        report($sformatf("unexpected output neuron %0d", out_data.neuron_index));
      end else begin
        want = neuron_queue.pop_front();
        if (out_data.neuron_index !== want.neuron_index)
          report($sformatf("neuron_index got %0d want %0d",
                           out_data.neuron_index, want.neuron_index));
        if (out_data.activation_value !== want.activation_value)
          report($sformatf("neuron %0d value got %0d want %0d", want.neuron_index,
                           out_data.activation_value, want.activation_value));
        if (out_data.last_output !== want.last_output)
          report($sformatf("neuron %0d last got %0b want %0b", want.neuron_index,
                           out_data.last_output, want.last_output));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    runs_sent    = 0;
    n_inputs_reg  = 7'd1;
    n_outputs_reg = 7'd1;
    mode_reg      = dlf_pkg::ACT_SIGMOID;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_stores();
    test_directed();
    test_drain_pause();
    test_random();
    wait_idle();

    if (neuron_queue.size() != 0) report("expected outputs left over");
    $display("Sent %0d items (%0d runs), checked %0d outputs", items_sent, runs_sent,
             results_seen);
    $display("Covered all activations, count clamping and saturation; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("** dense_layer_forward: PASSED **");
    end else begin
      $display("** dense_layer_forward: FAILED **");
    end
    $finish;
  end

endmodule
